/* rtl/tcmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcmc_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned IdxW    = 3;

  localparam logic [IdxW-1:0] RegPrimaryRed     = 3'd0;
  localparam logic [IdxW-1:0] RegPrimaryGreen   = 3'd1;
  localparam logic [IdxW-1:0] RegPrimaryBlue    = 3'd2;
  localparam logic [IdxW-1:0] RegPrimaryAlpha   = 3'd3;
  localparam logic [IdxW-1:0] RegSecondaryRed   = 3'd4;
  localparam logic [IdxW-1:0] RegSecondaryGreen = 3'd5;
  localparam logic [IdxW-1:0] RegSecondaryBlue  = 3'd6;
  localparam logic [IdxW-1:0] RegSecondaryAlpha = 3'd7;

  localparam logic [7:0] ByteMax = 8'd255;

  // Load enables for the two back stages of the pipeline
  typedef struct packed {
    logic s3;
    logic s4;
  } stage_en_t;

  // (x + 127) / 255 for x = a*b with a, b in 0..255, without a divider
  function automatic logic [7:0] div255_round(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, x} + 17'd128;
    u = t + {8'd0, t[16:8]};
    return u[15:8];
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? ByteMax : s[7:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/tcmc_channel.sv */
`timescale 1ns / 1ps
`default_nettype none

// One color channel: two products in stage 3, rounded and summed in stage 4
module tcmc_channel (
  input  wire logic                clk,
  input  wire tcmc_pkg::stage_en_t en,
  input  wire logic [7:0]          color_p,
  input  wire logic [7:0]          color_s,
  input  wire logic [7:0]          weight_p,
  input  wire logic [7:0]          weight_s,
  output logic [7:0]               chan
);

  logic [15:0] prod_p;
  logic [15:0] prod_s;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod_p <= {8'd0, color_p} * {8'd0, weight_p};
      prod_s <= {8'd0, color_s} * {8'd0, weight_s};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      chan <= tcmc_pkg::sat_add(tcmc_pkg::div255_round(prod_p),
                                tcmc_pkg::div255_round(prod_s));
    end
  end

endmodule

`default_nettype wire

/* rtl/two_color_mask_colorize.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: four register stages (coverage x alpha, weight rounding,
// color x weight, rounding and saturating sum); one item per cycle while
// the output drains, as m_tready low holds the pipeline back.
// Reset: rst (synchronous) empties the pipeline and loads the colors to
// opaque black (color 0, alpha 255) for both primary and secondary.
module two_color_mask_colorize (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // primary_coverage, secondary_coverage
  input  wire logic        s_tlast,   // line_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic             m_tlast    // row_last
);

  logic [7:0] regs [tcmc_pkg::NumRegs];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[tcmc_pkg::RegPrimaryRed]     <= 8'd0;
      regs[tcmc_pkg::RegPrimaryGreen]   <= 8'd0;
      regs[tcmc_pkg::RegPrimaryBlue]    <= 8'd0;
      regs[tcmc_pkg::RegPrimaryAlpha]   <= tcmc_pkg::ByteMax;
      regs[tcmc_pkg::RegSecondaryRed]   <= 8'd0;
      regs[tcmc_pkg::RegSecondaryGreen] <= 8'd0;
      regs[tcmc_pkg::RegSecondaryBlue]  <= 8'd0;
      regs[tcmc_pkg::RegSecondaryAlpha] <= tcmc_pkg::ByteMax;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: coverage times color alpha
  logic [15:0] prod_p, prod_s;
  logic        last1, last2, last3, last4;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod_p <= {8'd0, s_tdata[7:0]} * {8'd0, regs[tcmc_pkg::RegPrimaryAlpha]};
      prod_s <= {8'd0, s_tdata[15:8]} * {8'd0, regs[tcmc_pkg::RegSecondaryAlpha]};
      last1  <= s_tlast;
    end
  end

  // stage 2: rounded weights
  logic [7:0] weight_p, weight_s;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      weight_p <= tcmc_pkg::div255_round(prod_p);
      weight_s <= tcmc_pkg::div255_round(prod_s);
      last2    <= last1;
    end
  end

  // stages 3 and 4
  tcmc_pkg::stage_en_t en;
  logic [7:0] alpha3, alpha4;

  assign en = '{s3: rdy3, s4: rdy4};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      alpha3 <= tcmc_pkg::sat_add(weight_p, weight_s);
      last3  <= last2;
    end
    if (rdy4) begin
      alpha4 <= alpha3;
      last4  <= last3;
    end
  end

  logic [7:0] red, green, blue;

  tcmc_channel u_red (
    .clk      (clk),
    .en       (en),
    .color_p  (regs[tcmc_pkg::RegPrimaryRed]),
    .color_s  (regs[tcmc_pkg::RegSecondaryRed]),
    .weight_p (weight_p),
    .weight_s (weight_s),
    .chan     (red)
  );

  tcmc_channel u_green (
    .clk      (clk),
    .en       (en),
    .color_p  (regs[tcmc_pkg::RegPrimaryGreen]),
    .color_s  (regs[tcmc_pkg::RegSecondaryGreen]),
    .weight_p (weight_p),
    .weight_s (weight_s),
    .chan     (green)
  );

  tcmc_channel u_blue (
    .clk      (clk),
    .en       (en),
    .color_p  (regs[tcmc_pkg::RegPrimaryBlue]),
    .color_s  (regs[tcmc_pkg::RegSecondaryBlue]),
    .weight_p (weight_p),
    .weight_s (weight_s),
    .chan     (blue)
  );

  assign m_tvalid = v4;
  assign m_tdata  = {alpha4, blue, green, red};
  assign m_tlast  = last4;

endmodule

`default_nettype wire

/* verif/two_color_mask_colorize_tb.sv */
`timescale 1ns / 1ps

module two_color_mask_colorize_tb;

  localparam int unsigned PipeDepth    = 4;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned LongHold     = 150;
  localparam int unsigned HoldAfter    = 300;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems   = 144;
  localparam int unsigned NumRows      = 19;

  // Row fields in the order of the result bus, row_last on top
  typedef struct packed {
    logic       row_last;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [2:0] set;
    logic [7:0] pcov;
    logic [7:0] scov;
    logic       last;
    logic       typed;
    pixel_t     want;
  } mask_row_t;

  // Color settings: byte i holds register i (primary RGBA low, secondary RGBA high)
  localparam logic [63:0] ColorSets [5] = '{
    64'hFF000000_FF000000,   // reset values, opaque black
    64'hFFFFFFFF_FFFFFFFF,   // everything full: channel sums overflow
    64'h28FFFFFF_10FFFFFF,   // white colors over faint alphas
    64'h401E140A_803264C8,   // two unrelated colors
    64'h00000000_00000000    // fully transparent black
  };

  localparam pixel_t Blank = '0;

  localparam mask_row_t Rows [NumRows] = '{
    '{3'd0, 8'd0,   8'd0,   1'b0, 1'b1, '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0}},
    '{3'd0, 8'd255, 8'd0,   1'b1, 1'b1, '{1'b1, 8'd255, 8'd0,   8'd0,   8'd0}},
    '{3'd0, 8'd0,   8'd255, 1'b0, 1'b1, '{1'b0, 8'd255, 8'd0,   8'd0,   8'd0}},
    '{3'd0, 8'd255, 8'd255, 1'b1, 1'b1, '{1'b1, 8'd255, 8'd0,   8'd0,   8'd0}},
    '{3'd0, 8'd100, 8'd50,  1'b0, 1'b1, '{1'b0, 8'd150, 8'd0,   8'd0,   8'd0}},
    '{3'd0, 8'd200, 8'd100, 1'b0, 1'b1, '{1'b0, 8'd255, 8'd0,   8'd0,   8'd0}},
    '{3'd0, 8'd1,   8'd0,   1'b1, 1'b1, '{1'b1, 8'd1,   8'd0,   8'd0,   8'd0}},
    '{3'd1, 8'd255, 8'd255, 1'b0, 1'b1, '{1'b0, 8'd255, 8'd255, 8'd255, 8'd255}},
    '{3'd1, 8'd0,   8'd0,   1'b1, 1'b1, '{1'b1, 8'd0,   8'd0,   8'd0,   8'd0}},
    '{3'd1, 8'd255, 8'd0,   1'b0, 1'b1, '{1'b0, 8'd255, 8'd255, 8'd255, 8'd255}},
    '{3'd1, 8'd128, 8'd128, 1'b0, 1'b0, Blank},
    '{3'd2, 8'd255, 8'd255, 1'b1, 1'b0, Blank},
    '{3'd2, 8'd255, 8'd0,   1'b0, 1'b0, Blank},
    '{3'd2, 8'd37,  8'd201, 1'b1, 1'b0, Blank},
    '{3'd3, 8'd255, 8'd255, 1'b0, 1'b0, Blank},
    '{3'd3, 8'd1,   8'd254, 1'b1, 1'b0, Blank},
    '{3'd3, 8'd170, 8'd85,  1'b0, 1'b0, Blank},
    '{3'd4, 8'd255, 8'd255, 1'b1, 1'b1, '{1'b1, 8'd0,   8'd0,   8'd0,   8'd0}},
    '{3'd4, 8'd91,  8'd13,  1'b0, 1'b1, '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // primary_coverage, secondary_coverage
  logic        s_tlast = 1'b0;  // line_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // out_red, out_green, out_blue, out_alpha
  logic        m_tlast;         // row_last

  logic [7:0]  color_reg [tcmc_pkg::NumRegs];
  pixel_t      pending [$];
  pixel_t      head;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned row_ends = 0;
  int unsigned results_seen = 0;
  int unsigned settings_loaded = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic        gaps_on = 1'b1;
  logic        hold_done = 1'b0;

  two_color_mask_colorize dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // (a*b + 127) / 255
  function automatic logic [7:0] round_scale(input logic [7:0] a, input logic [7:0] b);
    int unsigned x;
    int unsigned y;
    int unsigned p;
    x = {24'd0, a};
    y = {24'd0, b};
    p = (x * y + 127) / 255;
    return p[7:0];
  endfunction

  function automatic logic [7:0] sat_sum(input logic [7:0] a, input logic [7:0] b);
    int unsigned s;
    s = {24'd0, a};
    s = s + {24'd0, b};
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic pixel_t colorize(input logic [7:0] pcov, input logic [7:0] scov,
                                      input logic last);
    logic [7:0] pw;
    logic [7:0] sw;
    pixel_t     px;
    pw = round_scale(pcov, color_reg[tcmc_pkg::RegPrimaryAlpha]);
    sw = round_scale(scov, color_reg[tcmc_pkg::RegSecondaryAlpha]);
    px.red   = sat_sum(round_scale(color_reg[tcmc_pkg::RegPrimaryRed], pw),
                       round_scale(color_reg[tcmc_pkg::RegSecondaryRed], sw));
    px.green = sat_sum(round_scale(color_reg[tcmc_pkg::RegPrimaryGreen], pw),
                       round_scale(color_reg[tcmc_pkg::RegSecondaryGreen], sw));
    px.blue  = sat_sum(round_scale(color_reg[tcmc_pkg::RegPrimaryBlue], pw),
                       round_scale(color_reg[tcmc_pkg::RegSecondaryBlue], sw));
    px.alpha = sat_sum(pw, sw);
    px.row_last = last;
    return px;
  endfunction

  function automatic logic [7:0] pick_coverage();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Called right after a rising edge with the block idle
  task automatic load_colors(input logic [63:0] setting);
    for (int i = 0; i < tcmc_pkg::NumRegs; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[tcmc_pkg::IdxW-1:0];
      cfg_data  <= setting[8*i +: 8];
      color_reg[i[tcmc_pkg::IdxW-1:0]] = setting[8*i +: 8];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  task automatic settle();
    while (pending.size() != 0) @(posedge clk);
    repeat (PipeDepth) @(posedge clk);
  endtask

  // Offer one item; the expectation is queued on the cycle it is taken
  task automatic send_pixel(input logic [7:0] pcov, input logic [7:0] scov, input logic last,
                            input logic typed, input pixel_t want);
    logic taken;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {scov, pcov};
    s_tlast  <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (s_tready) begin
        taken = 1'b1;
        pending.push_back(typed ? want : colorize(pcov, scov, last));
        items_sent++;
        if (last) row_ends++;
      end
      @(posedge clk);
    end
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Both handshakes are sampled mid-cycle, where everything is stable
  always @(negedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (m_tvalid && m_tready) begin
        if (pending.size() == 0) begin
          $error("result with no pixel pending: tdata %h tlast %b", m_tdata, m_tlast);
          errors++;
        end else begin
          head = pending.pop_front();
          check_field("out_red",   head.red,   m_tdata[7:0]);
          check_field("out_green", head.green, m_tdata[15:8]);
          check_field("out_blue",  head.blue,  m_tdata[23:16]);
          check_field("out_alpha", head.alpha, m_tdata[31:24]);
          check_field("row_last",  {7'd0, head.row_last}, {7'd0, m_tlast});
        end
        results_seen++;
      end
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(negedge clk);
    $display("FAILURE");
    $finish;
  end

  // Receiver: modes of random length, plus one long hold to back up the pipe
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned tick;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 80);
        end
        left--;
        tick++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 4) == 0);
          default: m_tready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    logic [2:0]  cur_set;
    logic [63:0] setting;
    for (int i = 0; i < tcmc_pkg::NumRegs; i++) begin
      color_reg[i[tcmc_pkg::IdxW-1:0]] = ColorSets[0][8*i +: 8];
    end
    cur_set = 3'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (Rows[r]) begin
      if (Rows[r].set != cur_set) begin
        s_tvalid <= 1'b0;
        settle();
        load_colors(ColorSets[Rows[r].set]);
        cur_set = Rows[r].set;
      end
      send_pixel(Rows[r].pcov, Rows[r].scov, Rows[r].last, Rows[r].typed, Rows[r].want);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      s_tvalid <= 1'b0;
      settle();
      for (int i = 0; i < tcmc_pkg::NumRegs; i++) begin
        case (p)
          0: setting[8*i +: 8] = 8'd255;
          1: setting[8*i +: 8] = 8'd0;
          2: setting[8*i +: 8] = (i % 4 == 3) ? 8'($urandom_range(0, 63)) : 8'd255;
          3: setting[8*i +: 8] = (i % 4 == 3) ? 8'd255 : 8'($urandom_range(0, 255));
          default: setting[8*i +: 8] = 8'($urandom_range(0, 255));
        endcase
      end
      load_colors(setting);
      gaps_on = (p % 3 != 2);
      for (int n = 0; n < PhaseItems; n++) begin
        send_pixel(pick_coverage(), pick_coverage(), ($urandom_range(0, 7) == 0), 1'b0, Blank);
      end
    end

    s_tvalid <= 1'b0;
    settle();
    $display("Sent %0d mask pixels (%0d row ends) over %0d color settings",
             items_sent, row_ends, settings_loaded);
    $display("Checked %0d RGBA results, %0d errors", results_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tcmc_pkg.sv
rtl/tcmc_channel.sv
rtl/two_color_mask_colorize.sv
verif/two_color_mask_colorize_tb.sv
